FILE: hdl/ofl_pkg.sv
package ofl_pkg;

   // loaded address bits, the rest of the 16-bit write address reads zero
   localparam int ADDRESS_WIDTH = 16;
   localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDRESS_WIDTH) - 32'd1);

   // write command queue between parser and writer
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   // one memory write
   typedef struct packed {
      logic [15:0] address;
      logic [15:0] data;
   } cmd_type;

   // queue status seen by the two sides
   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

FILE: hdl/ofl_parser.sv
module ofl_parser
   import ofl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        file_start,
   input  logic [7:0]  in_byte,
   output logic        push,
   output cmd_type     push_cmd
);

   typedef enum logic [6:0] {
      PH_HEADER = 7'b0000001,
      PH_ADDR   = 7'b0000010,
      PH_COUNT  = 7'b0000100,
      PH_BODY   = 7'b0001000,
      PH_SKIP   = 7'b0010000,
      PH_LINENO = 7'b0100000,
      PH_FINDEX = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_CODE   = 3'd1,
      KIND_DATA   = 3'd2,
      KIND_SYMBOL = 3'd3,
      KIND_FNAME  = 3'd4,
      KIND_LINE   = 3'd5
   } kind_type;

   localparam logic [15:0] HDR_CODE   = 16'hCADE;
   localparam logic [15:0] HDR_DATA   = 16'hDADA;
   localparam logic [15:0] HDR_SYMBOL = 16'hC3B7;
   localparam logic [15:0] HDR_FNAME  = 16'hF17E;
   localparam logic [15:0] HDR_LINE   = 16'h715E;

   phase_type   phase_ff, phase_in, phase_cur;
   kind_type    kind_ff, kind_in, kind_cur;
   logic [7:0]  held_ff, held_in;
   logic        pending_ff, pending_in, pending_cur;
   logic [15:0] addr_ff, addr_in, addr_cur;
   logic [15:0] left_ff, left_in, left_cur;
   logic [15:0] word;

   // a new file restarts the parser before its first byte is taken
   always_comb begin
      phase_cur   = file_start ? PH_HEADER : phase_ff;
      kind_cur    = file_start ? KIND_NONE : kind_ff;
      pending_cur = file_start ? 1'b0 : pending_ff;
      addr_cur    = file_start ? 16'd0 : addr_ff;
      left_cur    = file_start ? 16'd0 : left_ff;
   end

   assign word = {held_ff, in_byte};

   // byte pairing and section state machine
   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      held_in    = held_ff;
      pending_in = pending_ff;
      addr_in    = addr_ff;
      left_in    = left_ff;
      push       = 1'b0;
      push_cmd.address = addr_cur & ADDR_MASK;
      push_cmd.data    = word;
      if (accept) begin
         phase_in   = phase_cur;
         kind_in    = kind_cur;
         pending_in = pending_cur;
         addr_in    = addr_cur;
         left_in    = left_cur;
         if (phase_cur == PH_SKIP) begin
            left_in = left_cur - 16'd1;
            if (left_cur == 16'd1) begin
               phase_in = PH_HEADER;
            end
         end else if (!pending_cur) begin
            held_in    = in_byte;
            pending_in = 1'b1;
         end else begin
            pending_in = 1'b0;
            case (phase_cur)
               PH_HEADER: begin
                  case (word)
                     HDR_CODE: begin
                        kind_in  = KIND_CODE;
                        phase_in = PH_ADDR;
                     end
                     HDR_DATA: begin
                        kind_in  = KIND_DATA;
                        phase_in = PH_ADDR;
                     end
                     HDR_SYMBOL: begin
                        kind_in  = KIND_SYMBOL;
                        phase_in = PH_ADDR;
                     end
                     HDR_FNAME: begin
                        kind_in  = KIND_FNAME;
                        phase_in = PH_COUNT;
                     end
                     HDR_LINE: begin
                        kind_in  = KIND_LINE;
                        phase_in = PH_ADDR;
                     end
                     default: begin
                        // not a header, dropped
                     end
                  endcase
               end
               PH_ADDR: begin
                  addr_in  = word;
                  phase_in = (kind_cur == KIND_LINE) ? PH_LINENO : PH_COUNT;
               end
               PH_COUNT: begin
                  left_in = word;
                  if (word == 16'd0) begin
                     phase_in = PH_HEADER;
                  end else if (kind_cur inside {KIND_CODE, KIND_DATA}) begin
                     phase_in = PH_BODY;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_BODY: begin
                  push    = 1'b1;
                  addr_in = addr_cur + 16'd1;
                  left_in = left_cur - 16'd1;
                  if (left_cur == 16'd1) begin
                     phase_in = PH_HEADER;
                  end
               end
               PH_LINENO: begin
                  phase_in = PH_FINDEX;
               end
               PH_FINDEX: begin
                  phase_in = PH_HEADER;
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         kind_ff    <= KIND_NONE;
         held_ff    <= 8'd0;
         pending_ff <= 1'b0;
         addr_ff    <= 16'd0;
         left_ff    <= 16'd0;
      end else begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         held_ff    <= held_in;
         pending_ff <= pending_in;
         addr_ff    <= addr_in;
         left_ff    <= left_in;
      end
   end

endmodule

FILE: hdl/ofl_queue.sv
module ofl_queue
   import ofl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          head_cmd,
   output queue_status_type status
);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wptr_ff, wptr_in;
   logic [QPTR_WIDTH-1:0] rptr_ff, rptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;

   // pointer wrap at the queue depth
   function automatic logic [QPTR_WIDTH-1:0] next_ptr(input logic [QPTR_WIDTH-1:0] p);
      logic [QPTR_WIDTH-1:0] r;
      if (p == QPTR_WIDTH'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + QPTR_WIDTH'(1);
      end
      return r;
   endfunction

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign head_cmd     = entry_ff[rptr_ff];

   // pointer and fill count update
   always_comb begin
      wptr_in  = push ? next_ptr(wptr_ff) : wptr_ff;
      rptr_in  = pop ? next_ptr(rptr_ff) : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hdl/ofl_writer.sv
module ofl_writer
   import ofl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type status,
   input  cmd_type          head_cmd,
   output logic             pop,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output logic [15:0]      rsp_write_address,
   output logic [15:0]      rsp_write_data
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff;

   // load the output register from the queue whenever it is empty or being taken and the queue holds a command
   assign pop      = status.valid && (!valid_ff || rsp_ready);
   assign valid_in = pop ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head_cmd;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_write_address = cmd_ff.address;
   assign rsp_write_data    = cmd_ff.data;

endmodule

FILE: hdl/object_file_loader_unit.sv
// Object file loader.
// Request channel (req_valid/req_ready): one object file byte per transaction,
// req_in_byte, with req_file_start high on the first byte of each file.
// Response channel (rsp_valid/rsp_ready): one memory write per body word of a
// code or data section, rsp_write_address and rsp_write_data.
// Throughput is one byte per cycle while the queue is not full; the parser decides
// every byte in the cycle it is accepted, so pairing and section tracking never
// stall the input. The transaction carrying the low byte of a body word pushes
// its write into the command queue, from which it is loaded into the output
// register that drives rsp_valid.
// When the receiver stalls, the output register holds its write and the
// four-entry command queue keeps absorbing writes; req_ready drops only when
// the queue is full.
// Reset (synchronous) empties the queue and the output register and returns
// the parser to waiting for a header word; req_ready is low during reset.
module object_file_loader_unit
   import ofl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_file_start,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_write_address,
   output logic [15:0] rsp_write_data
);

   logic             accept;
   logic             push;
   logic             pop;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   queue_status_type status;

   // input handshake
   assign req_ready = !status.full && !reset;
   assign accept    = req_valid && req_ready;

   ofl_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .file_start (req_file_start),
      .in_byte    (req_in_byte),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   ofl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (status)
   );

   ofl_writer u_writer (
      .clock             (clock),
      .reset             (reset),
      .status            (status),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_write_address (rsp_write_address),
      .rsp_write_data    (rsp_write_data)
   );

endmodule

FILE: hdl/ofl_checker.sv
module ofl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_write_address,
   input logic [15:0] rsp_write_data
);

   // a stalled write holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_address)
         && $stable(rsp_write_data))
      else $error("stalled response changed");

   // reset leaves no write pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // reset leaves the queue empty, so the input is ready again
   assert property (@(posedge clock) reset |=> req_ready || reset)
      else $error("request not ready after reset");

   // a fresh write must be matched by an earlier accepted byte
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && $past(!reset, 2) && $rose(rsp_valid)
         |-> $past(req_valid && req_ready, 2))
      else $error("response without matching transaction");

endmodule

bind object_file_loader_unit ofl_checker u_ofl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_write_address (rsp_write_address),
   .rsp_write_data    (rsp_write_data)
);
